@@ rtl/ordered_list_insert_delete_macros.svh @@
// Assertion macros for the ordered list block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ORDERED_LIST_INSERT_DELETE_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OLID_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define OLID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/olid_pkg.sv @@
// ============================================================================
// olid_pkg
// Shared types and codes of the ordered list block: request codes, status
// codes and the result record passed from the engine to the output stage.
// ============================================================================
`default_nettype none

package olid_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic [1:0]         status;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/olid_req_if.sv @@
// ============================================================================
// olid_req_if
// Request channel: valid/ready handshake with the request type and value.
// ============================================================================
`default_nettype none

interface olid_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/olid_res_if.sv @@
// ============================================================================
// olid_res_if
// Result channel: valid/ready handshake with value, status and last flag.
// ============================================================================
`default_nettype none

interface olid_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_res;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, output value_res, output status, output last,
                  input ready);
  modport sink (input valid, input value_res, input status, input last,
                output ready);
endinterface

`default_nettype wire

@@ rtl/olid_ram.sv @@
// ============================================================================
// olid_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ============================================================================
`default_nettype none

module olid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/olid_engine.sv @@
// ============================================================================
// olid_engine
// List sequencer: owns the entry memory and the count, walks the memory for
// search, compaction and read-out, and hands results to the output stage.
// ============================================================================
`default_nettype none

module olid_engine
  import olid_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [31:0] value,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output res_t                    res
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0]         state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      idx, idx_next;
  logic [1:0]         pend, pend_next;
  logic signed [31:0] val, val_next;

  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_dec;
  logic          more;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  olid_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign idx_inc = idx + 1'b1;
  assign idx_dec = idx - 1'b1;
  // The walk continues while the entry after the current one is in use.
  assign more    = (idx_inc < count);

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    pend_next  = pend;
    val_next   = val;
    we         = 1'b0;
    waddr      = count[AW-1:0];
    wdata      = value;
    raddr      = idx[AW-1:0];
    req_ready  = (state == S_IDLE);
    res_valid  = 1'b0;
    res        = '{value_res: '0, status: pend, last: 1'b1};

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          val_next = value;
          case (req_type)
            REQ_INSERT: begin
              if (count >= CW'(DEPTH)) begin
                pend_next = ST_FULL;
              end else begin
                we         = 1'b1;
                count_next = count + 1'b1;
                pend_next  = ST_OK;
              end
              state_next = S_RESP;
            end
            REQ_DELETE: begin
              if (count == '0) begin
                pend_next  = ST_NOTFOUND;
                state_next = S_RESP;
              end else begin
                idx_next   = '0;
                raddr      = '0;
                state_next = S_SEARCH;
              end
            end
            REQ_READ: begin
              if (count == '0) begin
                pend_next  = ST_EMPTY;
                state_next = S_RESP;
              end else begin
                idx_next   = '0;
                raddr      = '0;
                state_next = S_READ;
              end
            end
            default: ;
          endcase
        end
      end

      S_SEARCH: begin
        if (rdata == $unsigned(val)) begin
          if (more) begin
            raddr      = idx_inc[AW-1:0];
            idx_next   = idx_inc;
            state_next = S_SHIFT;
          end else begin
            count_next = count - 1'b1;
            pend_next  = ST_OK;
            state_next = S_RESP;
          end
        end else if (more) begin
          raddr    = idx_inc[AW-1:0];
          idx_next = idx_inc;
        end else begin
          pend_next  = ST_NOTFOUND;
          state_next = S_RESP;
        end
      end

      S_SHIFT: begin
        // Move the entry just read one place toward the head.
        we    = 1'b1;
        waddr = idx_dec[AW-1:0];
        wdata = rdata;
        if (more) begin
          raddr    = idx_inc[AW-1:0];
          idx_next = idx_inc;
        end else begin
          count_next = count - 1'b1;
          pend_next  = ST_OK;
          state_next = S_RESP;
        end
      end

      S_READ: begin
        res_valid = 1'b1;
        res       = '{value_res: $signed(rdata), status: ST_OK, last: !more};
        if (res_ready) begin
          if (more) begin
            raddr    = idx_inc[AW-1:0];
            idx_next = idx_inc;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx  <= idx_next;
    pend <= pend_next;
    val  <= val_next;
  end

endmodule

`default_nettype wire

@@ rtl/ordered_list_insert_delete.sv @@
// ============================================================================
// ordered_list_insert_delete
// Ordered list of up to DEPTH signed 32-bit values kept in insertion order,
// with insert at tail, delete of the first match and full read-out.
// ============================================================================
//
// Channel  Role  Carries                      Per request
// -------  ----  ---------------------------  ------------------------------
// req      sink  req_type, value              one insert, delete or read-out
// rsp      src   value_res, status, last      one result, or one per entry for read
//
// An insert passes from acceptance through the response state to its result
// in the output register. A delete reads the entry memory once per cycle,
// first searching and then moving every later entry one place down, all
// through the single read port of that memory. A read-out streams one entry
// per cycle while rsp does not stall, once the first entry has been read.
// Reset clears only the state, the entry count and the output valid flag;
// the memory needs no clearing pass. A stall on rsp holds the read-out
// walk in place, and the next request is taken only after the last result
// of the previous one has been handed to the output register.
//
`default_nettype none

module ordered_list_insert_delete
  import olid_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  olid_req_if.sink  req,
  olid_res_if.source rsp
);

  logic eng_res_valid;
  logic eng_res_ready;
  res_t eng_res;

  // The engine walks the list memory and produces one result at a time.
  olid_engine #(.DEPTH(DEPTH)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .value     (req.value),
    .res_valid (eng_res_valid),
    .res_ready (eng_res_ready),
    .res       (eng_res)
  );

  // Output register: separates the engine from the consumer, so a read-out
  // can keep streaming at one result per cycle while the consumer takes it.
  logic out_valid;
  res_t out_res;

  assign eng_res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_res_valid && eng_res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (eng_res_valid && eng_res_ready) begin
      out_res <= eng_res;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.value_res = out_res.value_res;
  assign rsp.status    = out_res.status;
  assign rsp.last      = out_res.last;

endmodule

`default_nettype wire

@@ rtl/olid_checker.sv @@
// ============================================================================
// olid_checker
// Port-level checks of the ordered list block, bound to the top level.
// ============================================================================
`default_nettype none

`include "ordered_list_insert_delete_macros.svh"

module olid_checker
  import olid_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire logic [1:0]         req_type,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic signed [31:0] rsp_value_res,
  input wire logic [1:0]         rsp_status,
  input wire logic               rsp_last
);

  // A stalled result keeps its contents.
  `OLID_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value_res) && $stable(rsp_status) && $stable(rsp_last), "stalled result changed")

  // A request that produces results drops ready in the cycle after it is taken.
  `OLID_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready && ((req_type == REQ_INSERT) || (req_type == REQ_DELETE) || (req_type == REQ_READ)), !req_ready, "request taken while busy")

  // Error and empty outcomes are single results.
  `OLID_ASSERT_SAME(a_err_last, rsp_valid && (rsp_status != ST_OK), rsp_last, "error result not last")

  // Only read-out results carry a value.
  `OLID_ASSERT_SAME(a_err_zero, rsp_valid && (rsp_status != ST_OK), rsp_value_res == 32'sd0, "error result carries a value")

endmodule

bind ordered_list_insert_delete olid_checker u_olid_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_type      (req.req_type),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_value_res (rsp.value_res),
  .rsp_status    (rsp.status),
  .rsp_last      (rsp.last)
);

`default_nettype wire

@@ dv/tb.sv @@
// ============================================================================
// tb - testbench of the ordered list block
// Drives insert, delete and read-out requests into ordered_list_insert_delete
// with random gaps and result back-pressure. A scoreboard keeps its own copy
// of the list, works out every result that each accepted request must cause
// and checks the result stream against it in order.
// ============================================================================
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import olid_pkg::*;

  localparam int DEPTH = 16;

  // Request code 3 has no meaning. The block must swallow it without a result.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Counted requests in the random part. Unused requests do not count.
  localparam int RANDOM_ITEMS = 320;

  // A delete walks up to DEPTH entries and a read-out streams up to DEPTH results,
  // so a wait sized from the depth, with a margin, covers any late or stray result.
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

  // The worst case is far below this: even a full read-out for every request,
  // with each result held by a long stall, stays well under the limit.
  localparam longint CYCLE_LIMIT = 2_000_000;

  localparam int POOL_SIZE = 8;

  // --------------------------------------------------------------------------
  // Scoreboard: a shadow copy of the list and the queue of results it owes.
  // --------------------------------------------------------------------------
  class list_scoreboard;
    int unsigned        capacity;
    logic signed [31:0] contents[$];
    res_t               owed[$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        n_insert, n_delete, n_read, n_unused;
    int unsigned        n_full, n_notfound, n_empty;
    int unsigned        max_fill;

    function new(int unsigned cap);
      capacity = cap;
    endfunction

    function void owe(logic signed [31:0] v, logic [1:0] st, logic lst);
      res_t r;
      r.value_res = v;
      r.status    = st;
      r.last      = lst;
      owed.push_back(r);
    endfunction

    // Applies one accepted request to the shadow list and queues its results.
    function void note_request(logic [1:0] kind, logic signed [31:0] v);
      int hit;
      hit = -1;
      case (kind)
        REQ_INSERT: begin
          n_insert++;
          if (contents.size() >= capacity) begin
            n_full++;
            owe(0, ST_FULL, 1'b1);
          end else begin
            contents.push_back(v);
            if (contents.size() > max_fill) max_fill = contents.size();
            owe(0, ST_OK, 1'b1);
          end
        end
        REQ_DELETE: begin
          n_delete++;
          // Only the oldest matching entry goes; the rest keep their order.
          foreach (contents[i]) if (hit < 0 && contents[i] == v) hit = i;
          if (hit < 0) begin
            n_notfound++;
            owe(0, ST_NOTFOUND, 1'b1);
          end else begin
            contents.delete(hit);
            owe(0, ST_OK, 1'b1);
          end
        end
        REQ_READ: begin
          n_read++;
          if (contents.size() == 0) begin
            n_empty++;
            owe(0, ST_EMPTY, 1'b1);
          end else begin
            foreach (contents[i]) owe(contents[i], ST_OK, i == contents.size() - 1);
          end
        end
        default: n_unused++;
      endcase
    endfunction

    function void log_mismatch(string what, res_t want, res_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR (%0s): expected value_res=%0d status=%0d last=%0d, got %0d %0d %0d",
                 what, want.value_res, want.status, want.last,
                 got.value_res, got.status, got.last);
    endfunction

    // Compares one accepted result with the oldest owed result.
    function void check_result(res_t got);
      res_t  want;
      string bad;
      bad = "";
      checked++;
      if (owed.size() == 0) begin
        want = '0;
        log_mismatch("result with nothing outstanding", want, got);
        return;
      end
      want = owed.pop_front();
      if (got.value_res !== want.value_res) bad = {bad, " value_res"};
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.last !== want.last) bad = {bad, " last"};
      if (bad != "") log_mismatch({"wrong", bad}, want, got);
    endfunction

    // Anything still owed at the end never came out of the block.
    function void check_drained();
      res_t none;
      none = 'x;
      while (owed.size() != 0) log_mismatch("result never arrived", owed.pop_front(), none);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself.
  // --------------------------------------------------------------------------
  logic   clk;
  logic   rst;
  longint cycles = 0;
  bit     quiet = 1'b0;   // when set, neither side inserts idle cycles

  olid_req_if req_if ();
  olid_res_if rsp_if ();

  ordered_list_insert_delete #(
    .DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  list_scoreboard     board = new(DEPTH);
  logic signed [31:0] pool[POOL_SIZE];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // Every input of the block holds a known value from time zero.
  initial begin
    rst            <= 1'b1;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_INSERT;
    req_if.value    <= '0;
    rsp_if.ready    <= 1'b0;
  end

  // Idle lengths: mostly none or a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: ready comes in runs of random length broken by stalls of
  // random length, so a stall can land on any result of a read-out stream.
  initial begin
    int stall;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Result monitor. Sampling at the edge sees the values from before it.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready)
      board.check_result(res_t'{rsp_if.value_res, rsp_if.status, rsp_if.last});
  end

  // Sends one request. It is entered at a rising edge and returns at the edge
  // where the request was accepted, with valid still high, so a following
  // request with no gap changes only the payload and valid is never toggled
  // twice in one step.
  task automatic send_request(input logic [1:0] kind, input logic signed [31:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.value    <= v;
    do @(posedge clk); while (!req_if.ready);
    board.note_request(kind, v);
  endtask

  // Value source for random requests: a small pool gives repeats so that deletes
  // find matches and duplicates build up; some values come from the list itself, the rest is fully random.
  function automatic logic signed [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 8 && board.contents.size() != 0)
      return board.contents[$urandom_range(0, board.contents.size() - 1)];
    return $urandom;
  endfunction

  // Delete targets lean on the stored values, so most deletes really remove
  // an entry, from any position, and the shifting path gets exercised.
  function automatic logic signed [31:0] pick_delete_value();
    if (board.contents.size() != 0 && $urandom_range(0, 3) != 0)
      return board.contents[$urandom_range(0, board.contents.size() - 1)];
    return pick_value();
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    int         counted;
    int         phase;
    int         span;
    int         roll;
    logic [1:0] kind;

    pool[0] = 32'sh8000_0000;
    pool[1] = 32'sh7FFF_FFFF;
    pool[2] = 0;
    pool[3] = -1;
    pool[4] = 1;
    for (int i = 5; i < POOL_SIZE; i++) pool[i] = $urandom;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part. An empty list first: a read-out reports empty, a delete
    // reports not found, and an unused request code causes nothing.
    send_request(REQ_READ, 0);
    send_request(REQ_DELETE, 5);
    send_request(REQ_UNUSED, -1);
    // Deleting the sole entry must leave the list empty again.
    send_request(REQ_INSERT, 32'sh8000_0000);
    send_request(REQ_DELETE, 32'sh8000_0000);
    send_request(REQ_READ, 0);
    // Fill the list with the value extremes, a duplicate and random values.
    send_request(REQ_INSERT, 32'sh7FFF_FFFF);
    send_request(REQ_INSERT, 32'sh8000_0000);
    send_request(REQ_INSERT, -1);
    send_request(REQ_INSERT, 0);
    send_request(REQ_INSERT, 32'sh7FFF_FFFF);
    for (int i = 0; i < DEPTH - 5; i++) send_request(REQ_INSERT, $urandom);
    // An insert on a full list is refused; the read-out streams all entries.
    send_request(REQ_INSERT, 32'sh1234_5678);
    send_request(REQ_READ, 0);
    // The oldest of the two duplicates goes, then a miss, then the newest entry.
    send_request(REQ_DELETE, 32'sh7FFF_FFFF);
    send_request(REQ_DELETE, 1);
    send_request(REQ_DELETE, board.contents[$]);
    send_request(REQ_READ, 0);

    // Random part, in phases that grow the list toward full, shrink it toward
    // empty or mix both. About one phase in four runs without idle cycles.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      phase = $urandom_range(0, 2);
      span  = $urandom_range(20, 50);
      quiet = ($urandom_range(0, 3) == 0);
      while (span > 0 && counted < RANDOM_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll >= 95) kind = REQ_UNUSED;
        else if (roll >= 80) kind = REQ_READ;
        else if (phase == 0) kind = (roll < 65) ? REQ_INSERT : REQ_DELETE;
        else if (phase == 1) kind = (roll < 20) ? REQ_INSERT : REQ_DELETE;
        else kind = (roll < 45) ? REQ_INSERT : REQ_DELETE;
        if (kind == REQ_DELETE) send_request(kind, pick_delete_value());
        else send_request(kind, pick_value());
        if (kind != REQ_UNUSED) begin
          counted++;
          span--;
        end
      end
    end
    req_if.valid <= 1'b0;
    quiet = 1'b0;

    // Wait for every owed result, then give the block time to show any
    // stray result before the leftovers are judged.
    while (board.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    board.check_drained();

    $display("Covered %0d inserts (%0d refused as full), %0d deletes (%0d misses), %0d reads",
             board.n_insert, board.n_full, board.n_delete, board.n_notfound, board.n_read);
    $display("(%0d of an empty list), %0d unused codes; %0d results, list reached %0d entries.",
             board.n_empty, board.n_unused, board.checked, board.max_fill);
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles", cycles);
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
